@@ rtl/i2c_eeprom_transfer_sequencer_assert.svh @@
// ----------------------------------------------------------------------------
// I2C EEPROM transfer sequencer assertion macros
// Clocked implication checks, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef I2C_EEPROM_TRANSFER_SEQUENCER_ASSERT_SVH
`define I2C_EEPROM_TRANSFER_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define IETSEQ_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ietseq assertion failed");

// next-cycle implication
`define IETSEQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ietseq assertion failed");

`endif

@@ rtl/ietseq_pkg.sv @@
// ----------------------------------------------------------------------------
// I2C EEPROM transfer sequencer package
// Widths, bus command codes, sequencer step codes and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package ietseq_pkg;

   localparam int unsigned ADDR_W         = 19;
   localparam int unsigned BYTE_W         = 8;
   localparam int unsigned CMD_W          = 3;
   localparam int unsigned STEP_W         = 5;
   localparam int unsigned PAGE_BYTES_DEF = 256;

   // bus commands
   localparam logic [CMD_W-1:0] CMD_STOP      = 3'd0;
   localparam logic [CMD_W-1:0] CMD_START     = 3'd1;
   localparam logic [CMD_W-1:0] CMD_WRITE     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_RD_ACK    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_RD_NACK   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_PAGE_WAIT = 3'd5;
   localparam logic [CMD_W-1:0] CMD_WP_LOW    = 3'd6;
   localparam logic [CMD_W-1:0] CMD_WP_HIGH   = 3'd7;

   // device select bytes per bank
   localparam logic [BYTE_W-1:0] SEL_BANK0  = 8'hA8;
   localparam logic [BYTE_W-1:0] SEL_BANK1  = 8'hA4;
   localparam logic [BYTE_W-1:0] SEL_BANK2  = 8'hAC;
   localparam logic [BYTE_W-1:0] SEL_BANK3  = 8'hA0;
   localparam logic [BYTE_W-1:0] SEL_HI_BLK = 8'h02;

   // sequencer steps
   localparam logic [STEP_W-1:0] ST_STOP0     = 5'd0;
   localparam logic [STEP_W-1:0] ST_WP_LOW    = 5'd1;
   localparam logic [STEP_W-1:0] ST_STOP1     = 5'd2;
   localparam logic [STEP_W-1:0] ST_START     = 5'd3;
   localparam logic [STEP_W-1:0] ST_SEL       = 5'd4;
   localparam logic [STEP_W-1:0] ST_AHI       = 5'd5;
   localparam logic [STEP_W-1:0] ST_ALO       = 5'd6;
   localparam logic [STEP_W-1:0] ST_RSTART    = 5'd7;
   localparam logic [STEP_W-1:0] ST_RSEL      = 5'd8;
   localparam logic [STEP_W-1:0] ST_READ      = 5'd9;
   localparam logic [STEP_W-1:0] ST_READ_STOP = 5'd10;
   localparam logic [STEP_W-1:0] ST_WDATA     = 5'd11;
   localparam logic [STEP_W-1:0] ST_END_STOP  = 5'd12;
   localparam logic [STEP_W-1:0] ST_WP_HIGH   = 5'd13;
   localparam logic [STEP_W-1:0] ST_END_WAIT  = 5'd14;
   localparam logic [STEP_W-1:0] ST_PG_STOP   = 5'd15;
   localparam logic [STEP_W-1:0] ST_PG_WAIT   = 5'd16;

   typedef struct packed {
      logic              func;
      logic [ADDR_W-1:0] address;
      logic [BYTE_W-1:0] data;
      logic              first;
      logic              last;
   } ietseq_req_type;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [BYTE_W-1:0] bus_byte;
      logic              final_res;
   } ietseq_rsp_type;

   // one accepted transaction with the session state it sees
   typedef struct packed {
      logic              rd;
      logic              first;
      logic              last;
      logic [BYTE_W-1:0] data;
      logic [BYTE_W-1:0] sel;
      logic [ADDR_W-1:0] addr_cur;
      logic [ADDR_W-1:0] addr_nxt;
      logic [STEP_W-1:0] start_step;
   } ietseq_item_type;

   typedef struct packed {
      logic done;
      logic busy;
      logic page;
   } ietseq_ctrl_type;

   // map address bits 18:16 to the device select byte
   function automatic logic [BYTE_W-1:0] map_select(input logic [ADDR_W-1:0] addr);
      logic [BYTE_W-1:0] s;
      unique case (addr[ADDR_W-1 -: 2])
         2'd0: s = SEL_BANK0;
         2'd1: s = SEL_BANK1;
         2'd2: s = SEL_BANK2;
         default: s = SEL_BANK3;
      endcase
      if (addr[ADDR_W-3]) begin
         s = s | SEL_HI_BLK;
      end
      return s;
   endfunction

endpackage

`default_nettype wire

@@ rtl/ietseq_intake.sv @@
// ----------------------------------------------------------------------------
// I2C EEPROM transfer sequencer intake
// Accepts transactions, keeps the session address and select, and holds one
// transaction with its state snapshot for the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module ietseq_intake (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  ietseq_pkg::ietseq_req_type   req_data,
   input  ietseq_pkg::ietseq_ctrl_type  ctrl,
   output ietseq_pkg::ietseq_item_type  item,
   output logic                         item_vld
);
   import ietseq_pkg::*;

   logic              item_vld_ff, item_vld_in;
   ietseq_item_type   item_ff, item_in;
   logic [ADDR_W-1:0] cur_addr_ff, cur_addr_in;
   logic [BYTE_W-1:0] dev_sel_ff, dev_sel_in;
   logic              accept;

   // hold while the current transaction still has commands to send
   assign req_stall = item_vld_ff && !ctrl.done;
   assign accept    = req_valid && !req_stall;

   // latch session state on a first byte, step the write pointer
   always_comb begin
      item_in.rd       = req_data.func;
      item_in.first    = req_data.first;
      item_in.last     = req_data.last;
      item_in.data     = req_data.data;
      item_in.sel      = req_data.first ? map_select(req_data.address) : dev_sel_ff;
      item_in.addr_cur = req_data.first ? req_data.address : cur_addr_ff;
      item_in.addr_nxt = item_in.addr_cur + {{(ADDR_W-1){1'b0}}, 1'b1};
      priority if (req_data.first) begin
         item_in.start_step = ST_STOP0;
      end else if (req_data.func) begin
         item_in.start_step = ST_READ;
      end else begin
         item_in.start_step = ST_WDATA;
      end
      cur_addr_in = req_data.func ? item_in.addr_cur : item_in.addr_nxt;
      dev_sel_in  = item_in.sel;
      item_vld_in = accept || (item_vld_ff && !ctrl.done);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
         cur_addr_ff <= '0;
         dev_sel_ff  <= '0;
      end else begin
         item_vld_ff <= item_vld_in;
         if (accept) begin
            cur_addr_ff <= cur_addr_in;
            dev_sel_ff  <= dev_sel_in;
         end
      end
   end

   // transaction payload
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign item     = item_ff;
   assign item_vld = item_vld_ff;

endmodule

`default_nettype wire

@@ rtl/ietseq_emitter.sv @@
// ----------------------------------------------------------------------------
// I2C EEPROM transfer sequencer emitter
// Steps through the bus commands of the held transaction, one per cycle,
// into the result register if not stalled; detects page boundaries on writes.
// ----------------------------------------------------------------------------
`default_nettype none

module ietseq_emitter #(
   parameter int unsigned PAGE_BYTES = ietseq_pkg::PAGE_BYTES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ietseq_pkg::ietseq_item_type  item,
   input  logic                         item_vld,
   output ietseq_pkg::ietseq_ctrl_type  ctrl,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output ietseq_pkg::ietseq_rsp_type   rsp_data
);
   import ietseq_pkg::*;

   // floor(x / PAGE_BYTES) as (x * MUL) >> SH, exact for every address
   localparam int unsigned      SH     = ADDR_W + $clog2(PAGE_BYTES);
   localparam longint unsigned  MUL    = ((64'd1 << SH) + 64'(PAGE_BYTES) - 64'd1)
                                         / 64'(PAGE_BYTES);
   localparam int unsigned      MUL_W  = ADDR_W + 2;
   localparam int unsigned      PROD_W = ADDR_W + MUL_W;
   localparam logic [PROD_W-1:0] MUL_K = PROD_W'(MUL);

   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              page_ff, page_in;
   logic              rsp_valid_ff;
   ietseq_rsp_type    rsp_ff, rsp_in;

   logic [STEP_W-1:0] cur_step;
   logic [ADDR_W-1:0] addr_sel;
   logic [PROD_W-1:0] prod_cur, prod_nxt;
   logic              boundary;
   logic              out_ready;
   logic              emit;

   assign cur_step  = busy_ff ? step_ff : item.start_step;
   assign addr_sel  = page_ff ? item.addr_nxt : item.addr_cur;
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign emit      = item_vld && out_ready;

   // new address starts a page when the quotient changes or it wrapped
   assign prod_cur = PROD_W'(item.addr_cur) * MUL_K;
   assign prod_nxt = PROD_W'(item.addr_nxt) * MUL_K;
   assign boundary = (item.addr_nxt == '0) || ((prod_cur >> SH) != (prod_nxt >> SH));

   // command for the current step and the step after it
   always_comb begin
      rsp_in.command   = CMD_STOP;
      rsp_in.bus_byte  = '0;
      rsp_in.final_res = 1'b0;
      step_in          = ST_STOP0;
      page_in          = page_ff;
      unique case (cur_step)
         ST_STOP0: begin
            step_in = ST_WP_LOW;
         end
         ST_WP_LOW: begin
            rsp_in.command = CMD_WP_LOW;
            step_in        = ST_STOP1;
         end
         ST_STOP1: begin
            step_in = ST_START;
         end
         ST_START: begin
            rsp_in.command = CMD_START;
            step_in        = ST_SEL;
         end
         ST_SEL: begin
            rsp_in.command  = CMD_WRITE;
            rsp_in.bus_byte = item.sel;
            step_in         = ST_AHI;
         end
         ST_AHI: begin
            rsp_in.command  = CMD_WRITE;
            rsp_in.bus_byte = addr_sel[15:8];
            step_in         = ST_ALO;
         end
         ST_ALO: begin
            rsp_in.command   = CMD_WRITE;
            rsp_in.bus_byte  = addr_sel[7:0];
            rsp_in.final_res = page_ff;
            step_in          = item.rd ? ST_RSTART : ST_WDATA;
         end
         ST_RSTART: begin
            rsp_in.command = CMD_START;
            step_in        = ST_RSEL;
         end
         ST_RSEL: begin
            rsp_in.command  = CMD_WRITE;
            rsp_in.bus_byte = item.sel + 8'd1;
            step_in         = ST_READ;
         end
         ST_READ: begin
            rsp_in.command   = item.last ? CMD_RD_NACK : CMD_RD_ACK;
            rsp_in.final_res = !item.last;
            step_in          = ST_READ_STOP;
         end
         ST_READ_STOP: begin
            rsp_in.final_res = 1'b1;
         end
         ST_WDATA: begin
            rsp_in.command   = CMD_WRITE;
            rsp_in.bus_byte  = item.data;
            rsp_in.final_res = !item.last && !boundary;
            step_in          = item.last ? ST_END_STOP : ST_PG_STOP;
         end
         ST_END_STOP: begin
            step_in = ST_WP_HIGH;
         end
         ST_WP_HIGH: begin
            rsp_in.command = CMD_WP_HIGH;
            step_in        = ST_END_WAIT;
         end
         ST_END_WAIT: begin
            rsp_in.command   = CMD_PAGE_WAIT;
            rsp_in.final_res = 1'b1;
         end
         ST_PG_STOP: begin
            step_in = ST_PG_WAIT;
         end
         ST_PG_WAIT: begin
            rsp_in.command = CMD_PAGE_WAIT;
            step_in        = ST_START;
            page_in        = 1'b1;
         end
         default: begin
            rsp_in.final_res = 1'b1;
         end
      endcase
      busy_in = !rsp_in.final_res;
   end

   // advance the sequencer whenever the result register can take a command
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ST_STOP0;
         busy_ff      <= 1'b0;
         page_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= item_vld;
         if (item_vld) begin
            step_ff <= step_in;
            busy_ff <= busy_in;
            page_ff <= busy_in && page_in;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign ctrl.done = emit && rsp_in.final_res;
   assign ctrl.busy = busy_ff;
   assign ctrl.page = page_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

@@ rtl/i2c_eeprom_transfer_sequencer.sv @@
// A transaction's first command is registered in the intake, then in the
// result register. One bus command is sent per cycle while the result port
// is not stalled; a transaction causes 1 to 14 bus commands.
// The next transaction is accepted in the cycle its predecessor's last command
// is registered. Reset (synchronous) clears address and select to zero.
// ----------------------------------------------------------------------------
// I2C EEPROM transfer sequencer
// Turns read and write transaction bytes into I2C bus commands for a bank of
// serial EEPROMs, with session setup, page splitting and write protection.
// ----------------------------------------------------------------------------
`default_nettype none

`include "i2c_eeprom_transfer_sequencer_assert.svh"

module i2c_eeprom_transfer_sequencer #(
   parameter int unsigned PAGE_BYTES = ietseq_pkg::PAGE_BYTES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  ietseq_pkg::ietseq_req_type  req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output ietseq_pkg::ietseq_rsp_type  rsp_data
);
   import ietseq_pkg::*;

   ietseq_item_type item;
   logic            item_vld;
   ietseq_ctrl_type ctrl;

   // accept transactions and hold the session state
   ietseq_intake u_intake (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .ctrl      (ctrl),
      .item      (item),
      .item_vld  (item_vld)
   );

   // send the bus commands of the held transaction
   ietseq_emitter #(
      .PAGE_BYTES (PAGE_BYTES)
   ) u_emitter (
      .clock     (clock),
      .reset     (reset),
      .item      (item),
      .item_vld  (item_vld),
      .ctrl      (ctrl),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // an accepted transaction is held for the emitter
   `IETSEQ_ASSERT_NEXT(a_accept_held, clock, reset, req_valid && !req_stall, item_vld)
   // mid-transaction stepping needs a held transaction
   `IETSEQ_ASSERT_NOW(a_busy_has_item, clock, reset, ctrl.busy, item_vld)
   // re-addressing after a page wait only inside a transaction
   `IETSEQ_ASSERT_NOW(a_page_in_busy, clock, reset, ctrl.page, ctrl.busy)

endmodule

`default_nettype wire

@@ verif/i2c_eeprom_transfer_sequencer_checker.sv @@
// ----------------------------------------------------------------------------
// I2C EEPROM transfer sequencer checker
// Watches both channels. It works out the bus commands that each accepted
// transaction should cause and compares every accepted command against the
// oldest one still outstanding.
// ----------------------------------------------------------------------------
module i2c_eeprom_transfer_sequencer_checker
   import ietseq_pkg::*;
#(
   parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_stall,
   input  ietseq_req_type req_data,
   input  logic           rsp_valid,
   input  logic           rsp_stall,
   input  ietseq_rsp_type rsp_data,
   output int             fail_count,
   output int             pending_count,
   output int             checked_count
);

   localparam logic [BYTE_W-1:0] BANK_SELECT [4] = '{SEL_BANK0, SEL_BANK1, SEL_BANK2, SEL_BANK3};
   localparam int MAX_REPORTS = 10;

   logic [ADDR_W-1:0] write_pointer  = '0;
   logic [BYTE_W-1:0] session_select = '0;
   ietseq_rsp_type    expected_cmds[$];
   ietseq_rsp_type    want;
   int                mismatches    = 0;
   int                commands_seen = 0;

   function automatic ietseq_rsp_type bus_cmd(input logic [CMD_W-1:0]  c,
                                              input logic [BYTE_W-1:0] b);
      ietseq_rsp_type r;
      r.command   = c;
      r.bus_byte  = b;
      r.final_res = 1'b0;
      return r;
   endfunction

   // bank from address bits 18:17, upper 64 KiB block from bit 16
   function automatic logic [BYTE_W-1:0] select_for(input logic [ADDR_W-1:0] a);
      return BANK_SELECT[a[18:17]] | (a[16] ? SEL_HI_BLK : 8'h00);
   endfunction

   // k-th command of the addressing run at the current write pointer
   function automatic ietseq_rsp_type addressing_cmd(input int k);
      case (k)
         0: return bus_cmd(CMD_START, 8'h00);
         1: return bus_cmd(CMD_WRITE, session_select);
         2: return bus_cmd(CMD_WRITE, write_pointer[15:8]);
         default: return bus_cmd(CMD_WRITE, write_pointer[7:0]);
      endcase
   endfunction

   // work out the commands of one transaction and queue them
   task automatic predict_bus_commands(input ietseq_req_type t);
      ietseq_rsp_type burst[$];
      if (t.first) begin
         write_pointer  = t.address;
         session_select = select_for(t.address);
         burst.push_back(bus_cmd(CMD_STOP, 8'h00));
         burst.push_back(bus_cmd(CMD_WP_LOW, 8'h00));
         burst.push_back(bus_cmd(CMD_STOP, 8'h00));
         for (int k = 0; k < 4; k++) burst.push_back(addressing_cmd(k));
         if (t.func) begin
            burst.push_back(bus_cmd(CMD_START, 8'h00));
            burst.push_back(bus_cmd(CMD_WRITE, session_select + 8'd1));
         end
      end
      if (t.func) begin
         if (t.last) begin
            burst.push_back(bus_cmd(CMD_RD_NACK, 8'h00));
            burst.push_back(bus_cmd(CMD_STOP, 8'h00));
         end else begin
            burst.push_back(bus_cmd(CMD_RD_ACK, 8'h00));
         end
      end else begin
         burst.push_back(bus_cmd(CMD_WRITE, t.data));
         write_pointer = write_pointer + 1'b1;
         if (t.last) begin
            burst.push_back(bus_cmd(CMD_STOP, 8'h00));
            burst.push_back(bus_cmd(CMD_WP_HIGH, 8'h00));
            burst.push_back(bus_cmd(CMD_PAGE_WAIT, 8'h00));
         end else if (write_pointer % PAGE_BYTES == 0) begin
            // page boundary: close, wait out the write cycle, re-address
            burst.push_back(bus_cmd(CMD_STOP, 8'h00));
            burst.push_back(bus_cmd(CMD_PAGE_WAIT, 8'h00));
            for (int k = 0; k < 4; k++) burst.push_back(addressing_cmd(k));
         end
      end
      burst[burst.size()-1].final_res = 1'b1;
      foreach (burst[i]) expected_cmds.push_back(burst[i]);
   endtask

   // compare accepted commands first, then predict from the accepted transaction
   always @(posedge clock) begin
      if (reset) begin
         write_pointer  = '0;
         session_select = '0;
         expected_cmds.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            commands_seen++;
            if (expected_cmds.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected bus command %0d: cmd %0d byte 0x%02h final %0b",
                           commands_seen, rsp_data.command, rsp_data.bus_byte,
                           rsp_data.final_res);
            end else begin
               want = expected_cmds.pop_front();
               if (rsp_data.command !== want.command || rsp_data.bus_byte !== want.bus_byte ||
                   rsp_data.final_res !== want.final_res) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display({"bus command %0d mismatch: expected cmd %0d byte 0x%02h ",
                               "final %0b, got cmd %0d byte 0x%02h final %0b"},
                              commands_seen, want.command, want.bus_byte, want.final_res,
                              rsp_data.command, rsp_data.bus_byte, rsp_data.final_res);
               end
            end
         end
         if (req_valid && !req_stall) predict_bus_commands(req_data);
      end
      fail_count    <= mismatches;
      pending_count <= expected_cmds.size();
      checked_count <= commands_seen;
   end

endmodule

@@ verif/i2c_eeprom_transfer_sequencer_tb.sv @@
// ----------------------------------------------------------------------------
// I2C EEPROM transfer sequencer testbench
// Drives directed and random read and write transfers into the sequencer,
// with random idling on both channels, one long hold-off of the command
// channel and drain pauses between phases. The checker beside the block
// predicts and compares every bus command; this module gives the verdict.
// ----------------------------------------------------------------------------
module i2c_eeprom_transfer_sequencer_tb;
   import ietseq_pkg::*;

   localparam int ITEM_TARGET   = 270;
   localparam int LONG_HOLD     = 120;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 20;

   logic           clock     = 1'b0;
   logic           reset     = 1'b1;
   logic           req_valid = 1'b0;
   logic           req_stall;
   ietseq_req_type req_data  = '0;
   logic           rsp_valid;
   logic           rsp_stall = 1'b0;
   ietseq_rsp_type rsp_data;

   int fail_count;
   int pending_count;
   int checked_count;
   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;
   int hold_requests  = 0;
   int bytes_sent     = 0;
   int transfers_sent = 0;
   int cycles         = 0;

   always #5 clock = ~clock;

   i2c_eeprom_transfer_sequencer #(
      .PAGE_BYTES(PAGE_BYTES_DEF)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   i2c_eeprom_transfer_sequencer_checker #(
      .PAGE_BYTES(PAGE_BYTES_DEF)
   ) i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .fail_count   (fail_count),
      .pending_count(pending_count),
      .checked_count(checked_count)
   );

   // command sink: long hold-off on request, else random stalls
   initial begin : command_sink
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = LONG_HOLD - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // offer one transaction from a falling edge, return at the falling edge after it is taken
   task automatic send_item(input logic func, input logic [ADDR_W-1:0] addr,
                            input logic [BYTE_W-1:0] data, input logic first,
                            input logic last);
      ietseq_req_type t;
      t.func    = func;
      t.address = addr;
      t.data    = data;
      t.first   = first;
      t.last    = last;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   // well-formed transfer of len bytes with random data
   task automatic send_transfer(input logic func, input logic [ADDR_W-1:0] addr, input int len);
      logic [31:0] rnd;
      for (int k = 0; k < len; k++) begin
         rnd = $urandom;
         send_item(func, (k == 0) ? addr : rnd[ADDR_W-1:0], rnd[31:24], k == 0,
                   k == len - 1);
      end
      transfers_sent++;
   endtask

   // drop valid and hold until every expected command has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // mostly well-formed transfers, some stray bytes with random flags
   task automatic random_traffic(input int upto);
      logic [31:0]       rnd;
      logic [ADDR_W-1:0] addr;
      int                len;
      while (bytes_sent < upto) begin
         rnd  = $urandom;
         addr = rnd[ADDR_W-1:0];
         if ($urandom_range(99) < 12) begin
            send_item(rnd[31], addr, rnd[30:23], rnd[22], rnd[21]);
         end else begin
            // steer some starts to the end of a page
            if (rnd[20:19] == 2'b00) addr[7:2] = '1;
            len = ($urandom_range(7) == 0) ? $urandom_range(30, 10) : $urandom_range(6, 1);
            send_transfer(rnd[31], addr, len);
         end
      end
   endtask

   initial begin : stimulus
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // bytes without a first straight after reset use select and address zero
      send_item(1'b0, 19'h00000, 8'hFF, 1'b0, 1'b0);
      send_item(1'b1, 19'h7FFFF, 8'h00, 1'b0, 1'b1);
      // top of memory: write wraps to zero on a page boundary
      send_item(1'b0, 19'h7FFFF, 8'h00, 1'b1, 1'b0);
      send_item(1'b0, 19'h00000, 8'hFF, 1'b0, 1'b1);
      // single-byte read, then a three-byte read
      send_item(1'b1, 19'h00000, 8'hFF, 1'b1, 1'b1);
      send_item(1'b1, 19'h2A5C3, 8'h55, 1'b1, 1'b0);
      send_item(1'b1, 19'h5A5A5, 8'hAA, 1'b0, 1'b0);
      send_item(1'b1, 19'h2A5C3, 8'h55, 1'b0, 1'b1);
      // write across a 64 KiB boundary keeps the latched select
      send_item(1'b0, 19'h4FFFE, 8'hAA, 1'b1, 1'b0);
      send_item(1'b0, 19'h00000, 8'h55, 1'b0, 1'b0);
      send_item(1'b0, 19'h00000, 8'hA5, 1'b0, 1'b1);
      // last byte landing on a page boundary closes without re-addressing
      send_item(1'b0, 19'h600FF, 8'h5A, 1'b1, 1'b1);
      // function changes inside one transfer
      send_item(1'b0, 19'h55555, 8'h55, 1'b1, 1'b0);
      send_item(1'b1, 19'h2AAAA, 8'hAA, 1'b0, 1'b0);
      send_item(1'b0, 19'h2AAAA, 8'hAA, 1'b0, 1'b1);
      send_item(1'b1, 19'h1FF00, 8'h0F, 1'b1, 1'b0);
      send_item(1'b1, 19'h1FF00, 8'hF0, 1'b0, 1'b1);
      send_item(1'b0, 19'h3FFFF, 8'h3C, 1'b1, 1'b0);
      send_item(1'b0, 19'h3FFFF, 8'hC3, 1'b0, 1'b1);
      send_item(1'b0, 19'h2AAAA, 8'hAA, 1'b1, 1'b1);
      wait_drained();

      // sender idles lightly, receiver heavily; hold commands back while a long write fills the block
      send_idle_pct = 32;
      recv_idle_pct = 88;
      hold_requests++;
      @(negedge clock);
      send_transfer(1'b0, 19'h00000, 40);
      random_traffic(120);
      wait_drained();

      // receiver idles lightly, sender heavily
      send_idle_pct = 88;
      recv_idle_pct = 32;
      @(negedge clock);
      random_traffic(200);
      wait_drained();

      // back to back on both sides
      send_idle_pct = 0;
      recv_idle_pct = 0;
      @(negedge clock);
      random_traffic(ITEM_TARGET);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("run covered %0d transaction bytes in %0d directed and random transfers",
               bytes_sent, transfers_sent);
      $display("%0d bus commands checked across three idling profiles and one long hold-off",
               checked_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("i2c_eeprom_transfer_sequencer_tb OK");
      end else begin
         $display("i2c_eeprom_transfer_sequencer_tb NOT OK");
      end
      $finish;
   end

   // cycle limit
   initial begin : watchdog
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles, %0d commands outstanding", cycles, pending_count);
      $display("i2c_eeprom_transfer_sequencer_tb NOT OK");
      $finish;
   end

endmodule
